@@ design/mibs80_pkg.sv @@
// mibs80_pkg: shared constants, types and round functions of the mibs-80 cipher
// no dependencies; imported by the controller, the datapath and the top level
package mibs80_pkg;

  localparam int MAX_ROUNDS_DEF = 32;

  localparam int KEY_HIGH_W = 16;
  localparam int KEY_LOW_W  = 64;
  localparam int RCNT_W     = 6;
  localparam int BLOCK_W    = 64;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 2'd2;

  // operation codes carried in the input tuser
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [3:0] SBOX [16] = '{
    4'd4, 4'd15, 4'd3, 4'd8, 4'd13, 4'd10, 4'd12, 4'd0,
    4'd11, 4'd5, 4'd7, 4'd14, 4'd2, 4'd6, 4'd1, 4'd9
  };

  // bit r set: input nibble r (from the top) feeds output nibble k
  localparam logic [7:0] MIX_SEL [8] = '{
    8'hDB, 8'h7E, 8'hB7, 8'hCE, 8'h9D, 8'h3B, 8'h67, 8'hED
  };

  // controller to datapath commands
  typedef struct packed {
    logic       key_load;    // copy key registers into the schedule registers
    logic       exp_step;    // one key schedule round, write its round key
    logic [5:0] exp_rnd;     // schedule round number, from one
    logic       blk_load;    // load the halves from the input beat
    logic       round_step;  // one feistel round
    logic       op;          // encrypt or decrypt
  } mibs80_cmd_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    return SBOX[x];
  endfunction

  // key xor, nibble s-box layer, nibble mixing
  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] x,
                                                input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] v;
    logic [3:0]        nib [8];
    logic [3:0]        acc;
    logic [HALF_W-1:0] res;
    v   = x ^ k;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      nib[i] = sbox4(v[HALF_W-1-4*i -: 4]);
    end
    for (int i = 0; i < 8; i++) begin
      acc = 4'd0;
      for (int r = 0; r < 8; r++) begin
        if (MIX_SEL[i][r]) begin
          acc = acc ^ nib[r];
        end
      end
      res[HALF_W-1-4*i -: 4] = acc;
    end
    return res;
  endfunction

endpackage

@@ design/mibs80_block_cipher.sv @@
// mibs80_block_cipher: top level of the mibs-80 feistel cipher
// depends on mibs80_pkg, mibs80_ctrl and mibs80_dp
// MIBS-80 block cipher, 64-bit block, 80-bit key. Write key_high (index 0),
// key_low (index 1) and round_count (index 2) on the cfg port; each write, and
// reset, reruns the key schedule: a load step, then one schedule round per
// clock into the round key store, during which in_tready is low. Each input
// beat carries the block in in_tdata and the operation in in_tuser (0 encrypt,
// 1 decrypt). After acceptance the feistel round unit runs one round per clock,
// fed by the one read port of the key store, for n rounds, n being round_count
// clamped to 1..MAX_ROUNDS; a final step then hands the result to the output
// register, waiting while that register is full and out_tready is low. The
// next block is accepted only after that hand-over, so the core works on one
// block at a time. A new block is accepted while the previous result still
// waits in the output register.
module mibs80_block_cipher #(
  parameter int MAX_ROUNDS = mibs80_pkg::MAX_ROUNDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mibs80_pkg::BLOCK_W-1:0]      in_tdata,   // [63:0] data_in
  input  logic                                in_tuser,   // [0] op
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mibs80_pkg::BLOCK_W-1:0]      out_tdata,  // [63:0] data_out
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mibs80_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mibs80_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mibs80_pkg::*;

  localparam int KW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  logic [KEY_HIGH_W-1:0] key_high_r;
  logic [KEY_LOW_W-1:0]  key_low_r;
  logic [RCNT_W-1:0]     round_count_r;
  logic                  cfg_hit;
  logic                  out_load;
  logic                  out_valid_r;
  logic [BLOCK_W-1:0]    out_data_r;
  logic [BLOCK_W-1:0]    dp_result;
  logic [KW-1:0]         rd_addr;
  mibs80_cmd_t           cmd;

  // writes beyond the register list are ignored
  assign cfg_hit = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW ||
                              cfg_index == CFG_ROUND_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r    <= '0;
      key_low_r     <= '0;
      round_count_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_HIGH:    key_high_r    <= cfg_wdata[KEY_HIGH_W-1:0];
        CFG_KEY_LOW:     key_low_r     <= cfg_wdata[KEY_LOW_W-1:0];
        CFG_ROUND_COUNT: round_count_r <= cfg_wdata[RCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mibs80_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .KW         (KW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_hit     (cfg_hit),
    .round_count (round_count_r),
    .in_tvalid   (in_tvalid),
    .in_op       (in_tuser),
    .in_tready   (in_tready),
    .out_full    (out_valid_r),
    .out_tready  (out_tready),
    .out_load    (out_load),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  mibs80_dp #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .KW         (KW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .key_high (key_high_r),
    .key_low  (key_low_r),
    .data_in  (in_tdata),
    .data_out (dp_result)
  );

  // output register parts the core from the result channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= dp_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/mibs80_ctrl.sv @@
// mibs80_ctrl: sequencer for key schedule and round iteration
// depends on mibs80_pkg; drives mibs80_dp through mibs80_cmd_t
module mibs80_ctrl #(
  parameter int MAX_ROUNDS = mibs80_pkg::MAX_ROUNDS_DEF,
  parameter int KW         = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_hit,
  input  logic [mibs80_pkg::RCNT_W-1:0]    round_count,
  input  logic                             in_tvalid,
  input  logic                             in_op,
  output logic                             in_tready,
  input  logic                             out_full,
  input  logic                             out_tready,
  output logic                             out_load,
  output mibs80_pkg::mibs80_cmd_t          cmd,
  output logic [KW-1:0]                    rd_addr
);
  import mibs80_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_EXP   = 2'd1;
  localparam logic [1:0] S_IDLE  = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  localparam logic [5:0] MAX_R = 6'(MAX_ROUNDS);

  logic [1:0]    state_r, state_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [KW-1:0] ka_r, ka_nxt;
  logic          op_r, op_nxt;
  logic          done_r, done_nxt;
  logic [5:0]    n_eff;
  logic [5:0]    n_m1;

  // zero means one round, above the store depth saturates
  always_comb begin
    if (round_count == 6'd0) begin
      n_eff = 6'd1;
    end else if (round_count > MAX_R) begin
      n_eff = MAX_R;
    end else begin
      n_eff = round_count;
    end
  end
  assign n_m1 = n_eff - 6'd1;

  assign in_tready = (state_r == S_IDLE) && !cfg_hit;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ka_nxt         = ka_r;
    op_nxt         = op_r;
    done_nxt       = done_r;
    rd_addr        = ka_r;
    out_load       = 1'b0;
    cmd            = '0;
    cmd.op         = op_r;
    cmd.exp_rnd    = cnt_r;
    case (state_r)
      S_LOAD: begin
        cmd.key_load = 1'b1;
        cnt_nxt      = 6'd1;
        state_nxt    = S_EXP;
      end
      S_EXP: begin
        cmd.exp_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == MAX_R) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.op = in_op;
        if (in_tvalid) begin
          cmd.blk_load = 1'b1;
          rd_addr      = (in_op == OP_DECRYPT) ? n_m1[KW-1:0] : '0;
          ka_nxt       = rd_addr;
          cnt_nxt      = n_eff;
          op_nxt       = in_op;
          done_nxt     = 1'b0;
          state_nxt    = S_ROUND;
        end
      end
      S_ROUND: begin
        if (!done_r) begin
          cmd.round_step = 1'b1;
          rd_addr        = (op_r == OP_DECRYPT) ? ka_r - KW'(1) : ka_r + KW'(1);
          ka_nxt         = rd_addr;
          cnt_nxt        = cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            done_nxt = 1'b1;
          end
        end else if (!out_full || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    // any register write reruns the key schedule
    if (cfg_hit) begin
      state_nxt = S_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= 6'd0;
      ka_r    <= '0;
      op_r    <= OP_ENCRYPT;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ka_r    <= ka_nxt;
      op_r    <= op_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

@@ design/mibs80_dp.sv @@
// mibs80_dp: key schedule registers, round key store and feistel halves
// depends on mibs80_pkg; commanded by mibs80_ctrl
module mibs80_dp #(
  parameter int MAX_ROUNDS = mibs80_pkg::MAX_ROUNDS_DEF,
  parameter int KW         = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mibs80_pkg::mibs80_cmd_t             cmd,
  input  logic [KW-1:0]                       rd_addr,
  input  logic [mibs80_pkg::KEY_HIGH_W-1:0]   key_high,
  input  logic [mibs80_pkg::KEY_LOW_W-1:0]    key_low,
  input  logic [mibs80_pkg::BLOCK_W-1:0]      data_in,
  output logic [mibs80_pkg::BLOCK_W-1:0]      data_out
);
  import mibs80_pkg::*;

  logic [KEY_HIGH_W-1:0] khi_r, khi_nxt;
  logic [KEY_LOW_W-1:0]  klo_r, klo_nxt;
  logic [HALF_W-1:0]     left_r, left_nxt;
  logic [HALF_W-1:0]     right_r, right_nxt;
  logic [HALF_W-1:0]     rk_r;
  logic [HALF_W-1:0]     new_rk;
  logic [KEY_LOW_W-1:0]  rot_lo;
  logic [15:0]           rot_hi;
  logic [5:0]            wr_m1;
  logic [HALF_W-1:0]     f_out;

  logic [HALF_W-1:0] rk_mem [MAX_ROUNDS];

  // rotate the 80-bit key right by 19, s-box the top two nibbles, add round number
  always_comb begin
    rot_hi  = klo_r[18:3];
    rot_lo  = {klo_r[2:0], khi_r, klo_r[63:19]};
    khi_nxt = {sbox4(rot_hi[15:12]), sbox4(rot_hi[11:8]), rot_hi[7:0]};
    klo_nxt = rot_lo ^ {45'd0, cmd.exp_rnd[4:0], 14'd0};
    new_rk  = {khi_nxt, klo_nxt[63:48]};
  end

  assign wr_m1 = cmd.exp_rnd - 6'd1;

  always_ff @(posedge clk) begin
    if (cmd.exp_step) begin
      rk_mem[wr_m1[KW-1:0]] <= new_rk;
    end
    rk_r <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      khi_r <= '0;
      klo_r <= '0;
    end else if (cmd.key_load) begin
      khi_r <= key_high;
      klo_r <= key_low;
    end else if (cmd.exp_step) begin
      khi_r <= khi_nxt;
      klo_r <= klo_nxt;
    end
  end

  // decrypt runs the mirrored round on the right half
  assign f_out = round_f((cmd.op == OP_DECRYPT) ? right_r : left_r, rk_r);

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    if (cmd.blk_load) begin
      if (cmd.op == OP_DECRYPT) begin
        right_nxt = data_in[BLOCK_W-1:HALF_W];
        left_nxt  = data_in[HALF_W-1:0];
      end else begin
        left_nxt  = data_in[BLOCK_W-1:HALF_W];
        right_nxt = data_in[HALF_W-1:0];
      end
    end else if (cmd.round_step) begin
      if (cmd.op == OP_DECRYPT) begin
        left_nxt  = right_r;
        right_nxt = f_out ^ left_r;
      end else begin
        left_nxt  = f_out ^ right_r;
        right_nxt = left_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign data_out = (cmd.op == OP_DECRYPT) ? {left_r, right_r} : {right_r, left_r};

endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench for mibs80_block_cipher, encrypt and decrypt over
// changing keys and round counts, with random gaps and stalls on both streams
// depends on mibs80_pkg and the mibs80_block_cipher rtl
module tb;
  import mibs80_pkg::*;

  // register index that no register answers to
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // s-box, entry i in bits [4i+3:4i]
  localparam logic [63:0] NIBBLE_SUB = 64'h9162_E75B_0CAD_83F4;
  // mixing taps, output nibble k in bits [8k+7:8k], bit r = input nibble r from the top
  localparam logic [63:0] MIX_TAPS = 64'hED67_3B9D_CEB7_7EDB;

  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BLOCKS  = 123;

  // expected-result store plus a private model of the cipher and its key schedule
  class block_scoreboard;
    logic [15:0] key_hi;
    logic [63:0] key_lo;
    logic [5:0]  rounds;
    logic [31:0] round_keys [32];
    logic [63:0] expected_blocks [$];
    int          mismatches;
    int          matched;

    function new();
      key_hi     = '0;
      key_lo     = '0;
      rounds     = 6'd32;
      mismatches = 0;
      matched    = 0;
      expand_round_keys();
    endfunction

    function logic [3:0] sub4(logic [3:0] x);
      return NIBBLE_SUB[4*x +: 4];
    endfunction

    function void expand_round_keys();
      logic [15:0] hi;
      logic [15:0] nhi;
      logic [63:0] lo;
      logic [63:0] nlo;
      int          rnd;
      hi = key_hi;
      lo = key_lo;
      for (rnd = 1; rnd <= MAX_ROUNDS_DEF; rnd++) begin
        // rotate the 80-bit key right by 19
        nhi = lo[18:3];
        nlo = (lo >> 19) | ({48'd0, hi} << 45) | (lo << 61);
        hi  = {sub4(nhi[15:12]), sub4(nhi[11:8]), nhi[7:0]};
        lo  = nlo ^ {45'd0, rnd[4:0], 14'd0};
        round_keys[rnd-1] = {hi, lo[63:48]};
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_KEY_HIGH:    key_hi = val[15:0];
        CFG_KEY_LOW:     key_lo = val;
        CFG_ROUND_COUNT: rounds = val[5:0];
        default:         return;
      endcase
      expand_round_keys();
    endfunction

    function logic [31:0] feistel_f(logic [31:0] x, logic [31:0] k);
      logic [31:0] v;
      logic [31:0] res;
      logic [3:0]  nib [8];
      logic [3:0]  acc;
      int          i;
      int          j;
      v   = x ^ k;
      res = '0;
      for (i = 0; i < 8; i++) begin
        nib[i] = sub4(v[31-4*i -: 4]);
      end
      for (i = 0; i < 8; i++) begin
        acc = '0;
        for (j = 0; j < 8; j++) begin
          if (MIX_TAPS[8*i+j]) begin
            acc = acc ^ nib[j];
          end
        end
        res[31-4*i -: 4] = acc;
      end
      return res;
    endfunction

    function logic [63:0] cipher_block(logic op, logic [63:0] blk);
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      int          n;
      int          i;
      // zero rounds run as one, anything above the maximum saturates
      n = (rounds == 0) ? 1 : ((rounds > MAX_ROUNDS_DEF) ? MAX_ROUNDS_DEF : rounds);
      if (op == OP_ENCRYPT) begin
        l = blk[63:32];
        r = blk[31:0];
        for (i = 0; i < n; i++) begin
          t = feistel_f(l, round_keys[i]) ^ r;
          r = l;
          l = t;
        end
        return {r, l};
      end
      r = blk[63:32];
      l = blk[31:0];
      for (i = n; i > 0; i--) begin
        t = l;
        l = r;
        r = feistel_f(l, round_keys[i-1]) ^ t;
      end
      return {l, r};
    endfunction

    function void note_block(logic op, logic [63:0] blk);
      expected_blocks.push_back(cipher_block(op, blk));
    endfunction

    function void check_block(logic [63:0] got);
      logic [63:0] want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: data_out with nothing expected: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_blocks.pop_front();
      if (got !== want) begin
        $display("%0t: data_out mismatch: expected %h, actual %h", $time, want, got);
        mismatches++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BLOCK_W-1:0]    in_tdata;   // [63:0] data_in
  logic                  in_tuser;   // [0] op
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BLOCK_W-1:0]    out_tdata;  // [63:0] data_out
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  block_scoreboard sb;

  int send_idle_pct;  // chance in percent that the sender skips a cycle
  int stall_pct;      // chance in percent that the receiver stalls a cycle
  bit hold_req;       // asks the receiver for one long hold-off
  int idle_cycles;
  int n_encrypt;
  int n_decrypt;
  int n_settings;

  mibs80_block_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 2-unit clock period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // input monitor: every accepted beat becomes an expectation
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_block(in_tuser, in_tdata);
      if (in_tuser == OP_DECRYPT) begin
        n_decrypt++;
      end else begin
        n_encrypt++;
      end
    end
  end

  // result monitor: every accepted beat is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_block(out_tdata);
    end
  end

  // watchdog: too long without any beat or register write ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, sb.expected_blocks.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, or one long hold-off when asked, timed here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one block and return at the edge that accepts it; tvalid stays up
  task automatic send_block(input logic op, input logic [63:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    in_tuser  <= op;
    do begin
      @(posedge clk);
    end while (!in_tready);
  endtask

  // stop offering and wait until every expected block has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_blocks.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // write the unused index first (must be ignored), then the three registers
  task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] rc);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int                    i;
    idx[0] = CFG_UNUSED;      val[0] = {$urandom, $urandom};
    idx[1] = CFG_KEY_HIGH;    val[1] = kh;
    idx[2] = CFG_KEY_LOW;     val[2] = kl;
    idx[3] = CFG_ROUND_COUNT; val[3] = rc;
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [63:0] blk;
    logic [63:0] rc;
    int          ph;
    int          k;
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_ENCRYPT;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_KEY_HIGH;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    n_encrypt     = 0;
    n_decrypt     = 0;
    n_settings    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: schedule of the all-zero key left by reset, 32 rounds
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, '1);
    send_block(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(OP_DECRYPT, 64'h5555_5555_5555_5555);
    wait_drained();

    // all-ones key with junk above the register widths, zero rounds run as one
    configure('1, '1, 64'hFFFF_FFFF_FFFF_FFC0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, '1);
    send_block(OP_ENCRYPT, {$urandom, $urandom});
    send_block(OP_DECRYPT, 64'h0);
    wait_drained();

    // round count 63 saturates to the maximum
    configure(64'h0, 64'h0, 64'd63);
    send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    send_block(OP_DECRYPT, 64'hFEDC_BA98_7654_3210);
    send_block(OP_ENCRYPT, '1);
    wait_drained();

    // single round
    configure(64'hFFFF, 64'h0, 64'd1);
    send_block(OP_ENCRYPT, {$urandom, $urandom});
    send_block(OP_DECRYPT, {$urandom, $urandom});
    send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
    wait_drained();

    // one above the maximum
    configure(64'h0, '1, 64'd33);
    send_block(OP_ENCRYPT, {$urandom, $urandom});
    send_block(OP_DECRYPT, {$urandom, $urandom});
    send_block(OP_DECRYPT, 64'h0);
    wait_drained();

    // random phases; each phase a new key and round count and one of four idling mixes
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(9))
        0:       rc = 64'd0;
        1:       rc = 64'd1;
        2:       rc = 64'd32;
        3:       rc = 64'd63;
        4:       rc = {$urandom, $urandom};
        default: rc = $urandom_range(MAX_ROUNDS_DEF, 1);
      endcase
      configure({$urandom, $urandom}, {$urandom, $urandom}, rc);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 49;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      // once, the receiver goes quiet while blocks keep coming, to back up the input
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      for (k = 0; k < PHASE_BLOCKS; k++) begin
        case ($urandom_range(15))
          0:       blk = 64'h0;
          1:       blk = '1;
          default: blk = {$urandom, $urandom};
        endcase
        send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, blk);
      end
      // sender pauses here until every result is out
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("blocks sent: %0d encrypt, %0d decrypt, over %0d key and round settings",
             n_encrypt, n_decrypt, n_settings);
    $display("results matched: %0d, mismatches: %0d, left over: %0d",
             sb.matched, sb.mismatches, sb.expected_blocks.size());
    if (sb.mismatches == 0 && sb.expected_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mibs80_pkg.sv
design/mibs80_ctrl.sv
design/mibs80_dp.sv
design/mibs80_block_cipher.sv
verif/tb.sv
